// ===== src/csr_spmv_pkg.sv =====
// shared constants and types for the csr sparse matrix-vector block
package csr_spmv_pkg;

    // store geometry
    localparam int MAX_ROWS     = 1024;
    localparam int MAX_COLS     = 1024;
    localparam int MAX_NONZEROS = 8192;

    // field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 13;
    localparam int COL_W   = 10;
    localparam int VAL_W   = 32;
    localparam int PTR_W   = 14;
    localparam int ROW_W   = 10;
    localparam int SUM_W   = 64;
    localparam int RIU_W   = 11;

    // derived address widths
    localparam int X_AW    = $clog2(MAX_COLS);
    localparam int RP_AW   = $clog2(MAX_ROWS + 1);
    localparam int NZ_AW   = $clog2(MAX_NONZEROS);
    localparam int NZ_W    = COL_W + VAL_W;

    // bus widths; the tdata widths are padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    // reset value of the row count register
    localparam logic [RIU_W-1:0] ROWS_RESET = RIU_W'(MAX_ROWS);

    // request kinds
    typedef enum logic [OP_W-1:0] {
        OP_WRITE_X   = 2'd0,
        OP_WRITE_PTR = 2'd1,
        OP_WRITE_NZ  = 2'd2,
        OP_COMPUTE   = 2'd3
    } op_t;

endpackage

// ===== src/csr_sparse_matrix_vector_multiply.sv =====
// top level of the csr sparse matrix-vector product block
// Loads x, row pointers and nonzeros through the input stream and returns one row's dot
// product per compute request. A write request (x element, row pointer or nonzero) leaves
// the block idle, ready for the next request. A compute request for a row with n nonzeros,
// n at least one, reads the row pointer memory twice, then issues one nonzero per cycle from
// the single read port of the nonzero memory into a three-stage read/multiply/accumulate
// tail, sees the tail drained and hands the result to the output register once that register
// is free. A row whose end pointer is not above its start pointer skips the nonzero walk, and
// a rejected row goes straight to the output register. The next request is taken in the cycle
// after the output register is loaded. The input side is held off while a compute request is
// in flight; the result waits in an output register so that the next request can be taken
// before it is read. Stores are not cleared at reset and
// must be written before they are used.
module csr_sparse_matrix_vector_multiply
    import csr_spmv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // row count register
    input  logic                   rows_in_use_wen,
    input  logic [RIU_W-1:0]       rows_in_use_wdata,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // index, column, value, pointer, zero pad
    input  logic [OP_W-1:0]        s_tuser,   // op
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // row, sum, zero pad
    output logic [M_TUSER_W-1:0]   m_tuser    // overflow, status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [RIU_W-1:0]          rows_in_use_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [PTR_W-1:0]          j_reg;
    logic [PTR_W-1:0]          hi_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic signed [VAL_W-1:0]   val2_reg;
    logic signed [SUM_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic                      ovf_reg;
    logic                      status_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic [M_TUSER_W-1:0]      m_tuser_reg;

    op_t                       in_op;
    logic [IDX_W-1:0]          in_index;
    logic [COL_W-1:0]          in_column;
    logic [VAL_W-1:0]          in_value;
    logic [PTR_W-1:0]          in_pointer;
    logic                      accept;
    logic                      reject;
    logic                      issue;
    logic                      drained;

    logic                      x_we;
    logic [VAL_W-1:0]          x_rdata;
    logic                      rp_we;
    logic [RP_AW-1:0]          rp_raddr;
    logic [PTR_W-1:0]          rp_rdata;
    logic                      nz_we;
    logic [NZ_W-1:0]           nz_rdata;
    logic [COL_W-1:0]          nz_col;
    logic [VAL_W-1:0]          nz_val;
    logic                      col_ok;

    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   acc_sat;
    logic                      sat_hit;

    // pointers past the nonzero store are clamped to its depth
    function automatic logic [PTR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] lim;
        lim = PTR_W'(MAX_NONZEROS);
        clamp_ptr = (p > lim) ? lim : p;
    endfunction

    // request unpacking
    assign in_op      = op_t'(s_tuser);
    assign in_index   = s_tdata[IDX_W-1:0];
    assign in_column  = s_tdata[IDX_W+COL_W-1:IDX_W];
    assign in_value   = s_tdata[IDX_W+COL_W+VAL_W-1:IDX_W+COL_W];
    assign in_pointer = s_tdata[IDX_W+COL_W+VAL_W+PTR_W-1:IDX_W+COL_W+VAL_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign reject   = (in_index >= IDX_W'(rows_in_use_reg))
                   || (in_index >= IDX_W'(MAX_ROWS));

    // store writes, out-of-range positions dropped
    assign x_we  = accept && (in_op == OP_WRITE_X)   && (in_index < IDX_W'(MAX_COLS));
    assign rp_we = accept && (in_op == OP_WRITE_PTR) && (in_index <= IDX_W'(MAX_ROWS));
    assign nz_we = accept && (in_op == OP_WRITE_NZ)
                && ({1'b0, in_index} < (IDX_W + 1)'(MAX_NONZEROS));

    // row pointer read: start at accept, end in the following cycle
    assign rp_raddr = (state_reg == ST_IDLE) ? in_index[RP_AW-1:0]
                                             : ({1'b0, row_reg} + RP_AW'(1));

    assign nz_col = nz_rdata[NZ_W-1:VAL_W];
    assign nz_val = nz_rdata[VAL_W-1:0];
    assign col_ok = ({1'b0, nz_col} < (COL_W + 1)'(MAX_COLS));

    // nonzero walk control
    assign issue   = (state_reg == ST_RUN) && (j_reg < hi_reg);
    assign drained = !issue && !v1_reg && !v2_reg && !v3_reg;

    // saturating accumulate
    assign sum_wide = {acc_reg[SUM_W-1], acc_reg} + {prod_reg[SUM_W-1], prod_reg};
    assign sat_hit  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]);
    always_comb
    begin
        if (!sat_hit)
        begin
            acc_sat = sum_wide[SUM_W-1:0];
        end
        else if (sum_wide[SUM_W])
        begin
            acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    csr_spmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLS)
    ) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (in_index[X_AW-1:0]),
        .wdata (in_value),
        .raddr (nz_col[X_AW-1:0]),
        .rdata (x_rdata)
    );

    csr_spmv_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_ROWS + 1)
    ) u_rp_ram (
        .clk   (clk),
        .we    (rp_we),
        .waddr (in_index[RP_AW-1:0]),
        .wdata (in_pointer),
        .raddr (rp_raddr),
        .rdata (rp_rdata)
    );

    csr_spmv_ram #(
        .WIDTH (NZ_W),
        .DEPTH (MAX_NONZEROS)
    ) u_nz_ram (
        .clk   (clk),
        .we    (nz_we),
        .waddr (in_index[NZ_AW-1:0]),
        .wdata ({in_column, in_value}),
        .raddr (j_reg[NZ_AW-1:0]),
        .rdata (nz_rdata)
    );

    // control, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rows_in_use_reg <= ROWS_RESET;
            row_reg         <= '0;
            j_reg           <= '0;
            hi_reg          <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            val2_reg        <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            ovf_reg         <= 1'b0;
            status_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= '0;
        end
        else
        begin
            if (rows_in_use_wen)
            begin
                rows_in_use_reg <= rows_in_use_wdata;
            end

            // result taken, unless a new one is loaded below
            if (m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            // read, multiply and accumulate tail
            v1_reg <= issue;
            v2_reg <= v1_reg && col_ok;
            v3_reg <= v2_reg;
            val2_reg <= signed'(nz_val);
            prod_reg <= SUM_W'(val2_reg * signed'(x_rdata));
            if (issue)
            begin
                j_reg <= j_reg + PTR_W'(1);
            end
            if (v3_reg)
            begin
                acc_reg <= acc_sat;
                if (sat_hit)
                begin
                    ovf_reg <= 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (in_op == OP_COMPUTE))
                    begin
                        row_reg    <= in_index[ROW_W-1:0];
                        acc_reg    <= '0;
                        ovf_reg    <= 1'b0;
                        status_reg <= reject;
                        state_reg  <= reject ? ST_DONE : ST_LO;
                    end
                end
                ST_LO:
                begin
                    j_reg     <= clamp_ptr(rp_rdata);
                    state_reg <= ST_HI;
                end
                ST_HI:
                begin
                    hi_reg    <= clamp_ptr(rp_rdata);
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (drained)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({acc_reg, row_reg});
                        m_tuser_reg  <= {status_reg, ovf_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/csr_spmv_ram.sv =====
// generic single-write, single-read ram with registered read data
module csr_spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/csr_spmv_check.sv =====
// port checker for the csr sparse matrix-vector block and its bind
module csr_spmv_check
    import csr_spmv_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   rows_in_use_wen,
    input logic [RIU_W-1:0]       rows_in_use_wdata,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_TDATA_W-1:0]   s_tdata,
    input logic [OP_W-1:0]        s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata,
    input logic [M_TUSER_W-1:0]   m_tuser
);

    // a waiting result stays offered
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a waiting result does not change
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a rejected row carries a zero sum and no overflow
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[ROW_W+SUM_W-1:ROW_W] == '0) && !m_tuser[0])
        else $error("rejected row with nonzero sum or overflow");

    // a compute request holds off the input side in the next cycle
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_COMPUTE) |=> !s_tready)
        else $error("input taken right after a compute request");

    // result padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:ROW_W+SUM_W] == '0))
        else $error("result padding not zero");

endmodule

bind csr_sparse_matrix_vector_multiply csr_spmv_check u_csr_spmv_check (.*);

// ===== test/csr_spmv_checker.sv =====
// checker for the csr sparse matrix-vector block: predicts each row result and compares
module csr_spmv_checker
    import csr_spmv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rows_in_use_wen,
    input  logic [RIU_W-1:0]     rows_in_use_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending,
    output int                   result_count,
    output int                   overflow_count,
    output int                   reject_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // request field positions, lowest first
    localparam int COL_LSB = IDX_W;
    localparam int VAL_LSB = COL_LSB + COL_W;
    localparam int PTR_LSB = VAL_LSB + VAL_W;

    localparam longint SUM_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_BOTTOM = -SUM_TOP - 1;

    typedef struct {
        logic [ROW_W-1:0] row;
        longint           sum;
        logic             overflow;
        logic             status;
    } row_result_t;

    // row results still owed by the block, oldest first
    row_result_t expected_rows[$];

    // shadow of the register and the stores
    logic [RIU_W-1:0]        riu_shadow;
    logic signed [VAL_W-1:0] x_mem     [MAX_COLS];
    logic [PTR_W-1:0]        start_mem [MAX_ROWS+1];
    logic [COL_W-1:0]        col_mem   [MAX_NONZEROS];
    logic signed [VAL_W-1:0] nz_mem    [MAX_NONZEROS];

    initial
    begin
        riu_shadow     = ROWS_RESET;
        fail_count     = 0;
        pending        = 0;
        result_count   = 0;
        overflow_count = 0;
        reject_count   = 0;
    end

    // dot product of one row with x, saturating at each step
    function automatic row_result_t dot_row(int r);
        row_result_t res;
        int          lo;
        int          hi;
        longint      acc;
        longint      prod;
        longint      total;
        res.row      = ROW_W'(r);
        res.overflow = 1'b0;
        res.status   = 1'b0;
        acc          = 0;
        if (r >= int'(riu_shadow) || r >= MAX_ROWS)
        begin
            res.status = 1'b1;
        end
        else
        begin
            lo = (start_mem[r] > MAX_NONZEROS) ? MAX_NONZEROS : int'(start_mem[r]);
            hi = (start_mem[r+1] > MAX_NONZEROS) ? MAX_NONZEROS : int'(start_mem[r+1]);
            for (int j = lo; j < hi; j++)
            begin
                // a column past x adds nothing
                if (col_mem[j] < MAX_COLS)
                begin
                    prod  = longint'(nz_mem[j]) * longint'(x_mem[col_mem[j]]);
                    total = acc + prod;
                    if (((acc < 0) == (prod < 0)) && ((total < 0) != (acc < 0)))
                    begin
                        res.overflow = 1'b1;
                        total        = (acc < 0) ? SUM_BOTTOM : SUM_TOP;
                    end
                    acc = total;
                end
            end
        end
        res.sum = acc;
        return res;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        row_result_t      want;
        logic [IDX_W-1:0] idx;
        if (rst_n)
        begin
            // results leaving the block
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (m_tuser[0])
                    overflow_count++;
                if (m_tuser[1])
                    reject_count++;
                if (expected_rows.size() == 0)
                begin
                    $error("result for row %0d with no request waiting", m_tdata[ROW_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    check_field("row", want.row, m_tdata[ROW_W-1:0]);
                    check_field("sum", want.sum, $signed(m_tdata[ROW_W +: SUM_W]));
                    check_field("overflow", want.overflow, m_tuser[0]);
                    check_field("status", want.status, m_tuser[1]);
                end
            end

            // register write
            if (rows_in_use_wen)
                riu_shadow = rows_in_use_wdata;

            // requests entering the block
            if (s_tvalid && s_tready)
            begin
                idx = s_tdata[IDX_W-1:0];
                case (s_tuser)
                    OP_WRITE_X:
                    begin
                        if (idx < MAX_COLS)
                            x_mem[idx] = s_tdata[VAL_LSB +: VAL_W];
                    end
                    OP_WRITE_PTR:
                    begin
                        if (idx <= MAX_ROWS)
                            start_mem[idx] = s_tdata[PTR_LSB +: PTR_W];
                    end
                    OP_WRITE_NZ:
                    begin
                        if (idx < MAX_NONZEROS)
                        begin
                            col_mem[idx] = s_tdata[COL_LSB +: COL_W];
                            nz_mem[idx]  = s_tdata[VAL_LSB +: VAL_W];
                        end
                    end
                    default:
                    begin
                        expected_rows.insert(expected_rows.size(), dot_row(int'(idx)));
                    end
                endcase
            end
            pending = expected_rows.size();
        end
    end

endmodule

// ===== test/csr_sparse_matrix_vector_multiply_tb.sv =====
// testbench top for the csr sparse matrix-vector block: stimulus, handshakes and verdict
module csr_sparse_matrix_vector_multiply_tb;
    import csr_spmv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int PHASES          = 7;
    localparam int STALL_LIMIT     = 40000;
    localparam int PTR_MAX         = (1 << PTR_W) - 1;
    localparam int PAD_W           = S_TDATA_W - (PTR_W + VAL_W + COL_W + IDX_W);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 rows_in_use_wen = 1'b0;
    logic [RIU_W-1:0]     rows_in_use_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending;
    int result_count;
    int overflow_count;
    int reject_count;

    // sender-side view of the stores, so no unwritten entry is ever read
    bit           x_wr  [MAX_COLS];
    bit           rp_wr [MAX_ROWS+1];
    int           rp_val[MAX_ROWS+1];
    bit           nz_wr [MAX_NONZEROS];
    logic [COL_W-1:0] nz_col[MAX_NONZEROS];

    int cur_riu = MAX_ROWS;
    int requests_sent = 0;
    int stalled_cycles = 0;
    bit quiet = 1'b0;

    csr_sparse_matrix_vector_multiply i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .rows_in_use_wen   (rows_in_use_wen),
        .rows_in_use_wdata (rows_in_use_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser)
    );

    csr_spmv_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .rows_in_use_wen   (rows_in_use_wen),
        .rows_in_use_wdata (rows_in_use_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .fail_count        (fail_count),
        .pending           (pending),
        .result_count      (result_count),
        .overflow_count    (overflow_count),
        .reject_count      (reject_count)
    );

    always #5 clk = ~clk;

    // watchdog on cycles with no request and no result moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("FAIL csr_sparse_matrix_vector_multiply");
                $finish;
            end
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready   = 1'b0;
                stall_left = stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Q16.16 operand biased toward the extremes so sums saturate now and then
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return VAL_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            default: return $urandom();
        endcase
    endfunction

    // a compute of row r reads only entries already written
    function automatic bit row_safe(int r);
        int lo;
        int hi;
        if (r >= MAX_ROWS)
            return 1'b1;
        if (!rp_wr[r] || !rp_wr[r+1])
            return 1'b0;
        if (r >= cur_riu)
            return 1'b1;
        lo = (rp_val[r] > MAX_NONZEROS) ? MAX_NONZEROS : rp_val[r];
        hi = (rp_val[r+1] > MAX_NONZEROS) ? MAX_NONZEROS : rp_val[r+1];
        for (int j = lo; j < hi; j++)
        begin
            if (!nz_wr[j] || !x_wr[nz_col[j]])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int rows_held();
        return (cur_riu > MAX_ROWS) ? MAX_ROWS : cur_riu;
    endfunction

    // one request on the input stream, with an occasional gap ahead of it
    task automatic send_request(op_t op, int idx, int col, logic [VAL_W-1:0] val, int ptr);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap      = $urandom_range(1, 8);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {{PAD_W{1'b0}}, PTR_W'(ptr), val, COL_W'(col), IDX_W'(idx)};
        s_tvalid = 1'b1;
        requests_sent++;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic put_x(int idx, logic [VAL_W-1:0] val);
        if (idx < MAX_COLS)
            x_wr[idx] = 1'b1;
        send_request(OP_WRITE_X, idx, $urandom_range(0, MAX_COLS - 1), val,
                     $urandom_range(0, PTR_MAX));
    endtask

    task automatic put_pointer(int idx, int ptr);
        if (idx <= MAX_ROWS)
        begin
            rp_wr[idx]  = 1'b1;
            rp_val[idx] = ptr;
        end
        send_request(OP_WRITE_PTR, idx, $urandom_range(0, MAX_COLS - 1), $urandom(), ptr);
    endtask

    task automatic put_nonzero(int idx, int col, logic [VAL_W-1:0] val);
        if (idx < MAX_NONZEROS)
        begin
            nz_wr[idx]  = 1'b1;
            nz_col[idx] = COL_W'(col);
        end
        send_request(OP_WRITE_NZ, idx, col, val, $urandom_range(0, PTR_MAX));
    endtask

    task automatic ask_row(int r);
        send_request(OP_COMPUTE, r, $urandom_range(0, MAX_COLS - 1), $urandom(),
                     $urandom_range(0, PTR_MAX));
    endtask

    // compute of a random row, dropped when it would read an unwritten entry
    task automatic random_compute();
        int r;
        int lim;
        lim = rows_held();
        if ($urandom_range(0, 3) == 0)
            r = $urandom_range(0, (1 << IDX_W) - 1);
        else
            r = $urandom_range(0, ((lim == 0) ? MAX_ROWS : lim) - 1);
        if (row_safe(r))
            ask_row(r);
    endtask

    // load one row with random content, then compute it
    task automatic build_row();
        int r;
        int n;
        int lo;
        int hi_ptr;
        int lim;
        int c;
        bit pointers_first;
        lim = rows_held();
        if (lim == 0)
            r = $urandom_range(0, MAX_ROWS - 1);
        else if (lim < MAX_ROWS && $urandom_range(0, 9) == 0)
            r = $urandom_range(lim, MAX_ROWS - 1);
        else if ($urandom_range(0, 4) == 0)
            r = $urandom_range(0, lim - 1);
        else
            r = $urandom_range(0, ((lim < 64) ? lim : 64) - 1);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
        case ($urandom_range(0, 9))
            0:       lo = MAX_NONZEROS - n;
            1:       lo = 0;
            default: lo = $urandom_range(0, MAX_NONZEROS - n);
        endcase
        hi_ptr = lo + n;
        // end pointer past the store
        if (hi_ptr == MAX_NONZEROS && $urandom_range(0, 1))
            hi_ptr = $urandom_range(MAX_NONZEROS, PTR_MAX);
        // end pointer not above the start
        if ($urandom_range(0, 19) == 0)
        begin
            n      = 0;
            hi_ptr = $urandom_range(0, lo);
        end
        pointers_first = $urandom_range(0, 1);
        if (pointers_first)
        begin
            put_pointer(r, lo);
            put_pointer(r + 1, hi_ptr);
        end
        for (int j = 0; j < n; j++)
        begin
            c = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, MAX_COLS - 1);
            if (!x_wr[c] || $urandom_range(0, 7) == 0)
                put_x(c, rand_value());
            put_nonzero(lo + j, c, rand_value());
        end
        if (!pointers_first)
        begin
            put_pointer(r, lo);
            put_pointer(r + 1, hi_ptr);
        end
        ask_row(r);
        if ($urandom_range(0, 3) == 0)
            random_compute();
    endtask

    // unstructured request, often out of range and ignored
    task automatic noise_request();
        case ($urandom_range(0, 3))
            0:
            begin
                put_x($urandom_range(0, 1) ? $urandom_range(0, (1 << IDX_W) - 1)
                                           : $urandom_range(0, MAX_COLS - 1), rand_value());
            end
            1:
            begin
                put_pointer($urandom_range(0, 1) ? $urandom_range(0, (1 << IDX_W) - 1)
                                                 : $urandom_range(0, MAX_ROWS),
                            $urandom_range(0, PTR_MAX));
            end
            2:
            begin
                put_nonzero($urandom_range(0, MAX_NONZEROS - 1), $urandom_range(0, MAX_COLS - 1),
                            rand_value());
            end
            default:
            begin
                random_compute();
            end
        endcase
    endtask

    // register write once the block has drained
    task automatic set_rows_in_use(int v);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge clk);
        rows_in_use_wen   = 1'b1;
        rows_in_use_wdata = RIU_W'(v);
        @(negedge clk);
        rows_in_use_wen = 1'b0;
        cur_riu         = v;
    endtask

    initial
    begin
        int phase_end;

        // reset
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // x extremes and a unit value
        put_x(0, 32'h8000_0000);
        put_x(1, 32'h0001_0000);
        put_x(MAX_COLS - 1, 32'h7FFF_FFFF);
        // row 0 saturates high then falls back, row 2 saturates low
        put_nonzero(0, 0, 32'h8000_0000);
        put_nonzero(1, 0, 32'h8000_0000);
        put_nonzero(2, MAX_COLS - 1, 32'h8000_0000);
        put_nonzero(3, MAX_COLS - 1, 32'h8000_0000);
        put_nonzero(4, MAX_COLS - 1, 32'h8000_0000);
        put_nonzero(5, MAX_COLS - 1, 32'h8000_0000);
        put_nonzero(MAX_NONZEROS - 1, 1, 32'h7FFF_FFFF);
        // row 1 empty, rows 4 and 5 clamp to an empty range, row 6 clamps to the last entry
        put_pointer(0, 0);
        put_pointer(1, 3);
        put_pointer(2, 3);
        put_pointer(3, 6);
        put_pointer(4, PTR_MAX);
        put_pointer(5, 12000);
        put_pointer(6, MAX_NONZEROS - 1);
        put_pointer(7, 9000);
        ask_row(0);
        ask_row(1);
        ask_row(2);
        ask_row(4);
        ask_row(5);
        ask_row(6);
        // rejected rows, past the store and at the row limit
        ask_row((1 << IDX_W) - 1);
        ask_row(MAX_ROWS);

        // random loads and computes under several row counts
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:       set_rows_in_use(1);
                2:       set_rows_in_use(0);
                3:       set_rows_in_use((1 << RIU_W) - 1);
                4:       set_rows_in_use($urandom_range(2, MAX_ROWS - 1));
                5:       set_rows_in_use($urandom_range(2, 64));
                6:       set_rows_in_use(MAX_ROWS);
                default: ;
            endcase
            quiet     = (phase == PHASES - 1);
            phase_end = requests_sent + RANDOM_REQUESTS / PHASES;
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 7)
                    build_row();
                else
                    noise_request();
            end
        end

        // drain
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (50) @(negedge clk);

        $display("run: %0d requests, %0d row results, %0d saturated, %0d rejected",
                 requests_sent, result_count, overflow_count, reject_count);
        $display("row count held at reset, 1, 0, all ones, two random values and full");
        if (fail_count == 0 && pending == 0)
            $display("PASS csr_sparse_matrix_vector_multiply");
        else
            $display("FAIL csr_sparse_matrix_vector_multiply");
        $finish;
    end

endmodule
